### hw/rtl/mbhp_pkg.sv
// Package for the media box header parser: item and result structs,
// phase and status codes, and the fixed header constants.
// No dependencies; every module of the block imports it.
package mbhp_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_LARGE,
        PH_EXT
    } t_phase;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_END   = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

    localparam logic        ACT_BEGIN     = 1'b0;
    localparam logic [31:0] UUID_CODE     = 32'h7575_6964;
    localparam logic [31:0] SIZE_LARGE    = 32'd1;
    localparam logic [31:0] SIZE_TO_END   = 32'd0;
    localparam logic [63:0] FIXED_BYTES   = 64'd8;
    localparam logic [63:0] EXT_BYTES     = 64'd16;
    localparam logic [63:0] SPAN_END_ADD  = 64'd7;
    localparam logic [5:0]  HDR_BASE      = 6'd8;
    localparam logic [5:0]  HDR_LARGE_ADD = 6'd8;
    localparam logic [5:0]  HDR_EXT_ADD   = 6'd16;
    localparam logic [3:0]  LAST_FIXED    = 4'd7;
    localparam logic [3:0]  LAST_EXT      = 4'd15;

    typedef struct packed {
        logic        action;
        logic [63:0] span_left;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] box_type;
        logic [63:0] payload_bytes;
        logic [5:0]  header_bytes;
        logic        has_extended;
        logic [63:0] extended_high;
        logic [63:0] extended_low;
    } t_result;

endpackage

### hw/rtl/media_box_header_parser_unit.sv
// Media box header parser, top level.
// Input channel: i_valid / o_stall with i_action, i_span_left, i_data_byte.
// Output channel: o_valid / i_stall with the result fields.
// A transaction on either side completes at a rising edge where valid is high
// and stall is low. A begin transaction (action 0) opens a header and gives
// the bytes left in the enclosing span; data transactions (action 1) then
// carry the header bytes one per transaction. A result comes when the header
// is complete, found malformed, or the span holds fewer than eight bytes.
// An accepted transaction is held in the input register and is parsed into
// the result register at an edge where that register is free (no result, or
// i_stall low). One input transaction is taken per cycle while no result
// waits under i_stall; the rate is set by the single-byte parse step between
// the input and result registers. While a result waits under i_stall, one more
// input is still taken into the input register, after which o_stall rises.
// Reset (synchronous, active low) empties both registers and puts the parser
// in idle, where data bytes are dropped until a begin arrives.
// Depends on mbhp_pkg and mbhp_core.
module media_box_header_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [63:0] i_span_left,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_box_type,
    output logic [63:0] o_payload_bytes,
    output logic [5:0]  o_header_bytes,
    output logic        o_has_extended,
    output logic [63:0] o_extended_high,
    output logic [63:0] o_extended_low
);
    import mbhp_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;

    logic    w_accept;
    logic    w_out_free;
    logic    w_step;
    logic    w_emit;
    t_result w_result;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    mbhp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_item),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= w_step && w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.action    <= i_action;
            r_item.span_left <= i_span_left;
            r_item.data_byte <= i_data_byte;
        end
        if (w_step && w_emit) begin
            r_result <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_result.status;
    assign o_box_type      = r_result.box_type;
    assign o_payload_bytes = r_result.payload_bytes;
    assign o_header_bytes  = r_result.header_bytes;
    assign o_has_extended  = r_result.has_extended;
    assign o_extended_high = r_result.extended_high;
    assign o_extended_low  = r_result.extended_low;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_valid && i_stall && r_in_valid)
        else $error("input stalled without a blocked result");

    a_end_from_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_emit && (w_result.status == ST_END) |-> (r_item.action == ACT_BEGIN))
        else $error("end of span reported for a data byte");

    a_valid_hdr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_emit && (w_result.status == ST_VALID)
        |-> (w_result.header_bytes == 6'd8) || (w_result.header_bytes == 6'd16)
         || (w_result.header_bytes == 6'd24) || (w_result.header_bytes == 6'd32))
        else $error("valid header with an impossible header length");

    a_bad_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_emit && (w_result.status == ST_BAD)
        |-> (w_result.payload_bytes == 64'd0) && (w_result.header_bytes == 6'd0)
         && !w_result.has_extended)
        else $error("malformed result carries header fields");

endmodule

### hw/rtl/mbhp_core.sv
// Parser state machine and header datapath: advances by one item per step
// and reports the result that the item produces. Depends on mbhp_pkg.
module mbhp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  mbhp_pkg::t_item  i_item,
    output logic             o_emit,
    output mbhp_pkg::t_result o_result
);
    import mbhp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    // Span bytes left after the current byte, and that value plus eight.
    logic [63:0] r_bl_m1, n_bl_m1;
    logic [63:0] r_bl_p7, n_bl_p7;
    logic [31:0] r_size, n_size;
    logic [31:0] r_type, n_type;
    logic [63:0] r_large, n_large;
    logic [63:0] r_ext_hi, n_ext_hi;
    logic [63:0] r_ext_lo, n_ext_lo;

    logic        w_begin;
    logic        w_span_short;
    logic [7:0]  w_b;
    logic        w_hd_last, w_lg_last, w_ex_last;
    logic        w_size_large;
    logic [31:0] w_type_n;
    logic        w_uuid;
    logic [63:0] w_large_n;
    logic [63:0] w_ext_hi_n, w_ext_lo_n;
    logic [5:0]  w_hdr;
    logic [64:0] w_diff;
    logic        w_fin_fail;
    logic        w_fixed_done;
    logic        w_to_ext, w_fin;
    logic        w_bad, w_ok;

    assign w_begin      = (i_item.action == ACT_BEGIN);
    assign w_span_short = (i_item.span_left < FIXED_BYTES);
    assign w_b          = i_item.data_byte;
    assign w_hd_last    = (r_phase == PH_HEAD)  && (r_cnt == LAST_FIXED);
    assign w_lg_last    = (r_phase == PH_LARGE) && (r_cnt == LAST_FIXED);
    assign w_ex_last    = (r_phase == PH_EXT)   && (r_cnt == LAST_EXT);
    assign w_size_large = (r_size == SIZE_LARGE);

    assign w_type_n = ((r_phase == PH_HEAD) && r_cnt[2]) ? {r_type[23:0], w_b} : r_type;
    assign w_uuid   = (w_type_n == UUID_CODE);

    always_comb begin
        w_large_n = r_large;
        if (r_phase == PH_HEAD) begin
            w_large_n = (r_size == SIZE_TO_END) ? r_bl_p7 : {32'd0, r_size};
        end else if (r_phase == PH_LARGE) begin
            w_large_n = {r_large[55:0], w_b};
        end
    end

    assign w_ext_hi_n = ((r_phase == PH_EXT) && !r_cnt[3]) ? {r_ext_hi[55:0], w_b}
                                                           : r_ext_hi;
    assign w_ext_lo_n = ((r_phase == PH_EXT) && r_cnt[3]) ? {r_ext_lo[55:0], w_b}
                                                          : r_ext_lo;

    assign w_hdr = HDR_BASE + (w_size_large ? HDR_LARGE_ADD : 6'd0)
                            + (w_uuid ? HDR_EXT_ADD : 6'd0);
    // The top bit is the borrow: a total smaller than the header.
    assign w_diff     = {1'b0, w_large_n} - {59'd0, w_hdr};
    assign w_fin_fail = w_diff[64] || (w_diff[63:0] > r_bl_m1);

    assign w_fixed_done = (w_hd_last && !w_size_large) || w_lg_last;
    assign w_to_ext     = w_fixed_done && w_uuid;
    assign w_fin        = (w_fixed_done && !w_uuid) || w_ex_last;
    assign w_bad = (w_hd_last && w_size_large && (r_bl_m1 < FIXED_BYTES))
                || (w_to_ext && (r_bl_m1 < EXT_BYTES))
                || (w_fin && w_fin_fail);
    assign w_ok  = w_fin && !w_fin_fail;

    // Next state and datapath.
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_bl_m1  = r_bl_m1;
        n_bl_p7  = r_bl_p7;
        n_size   = r_size;
        n_type   = r_type;
        n_large  = r_large;
        n_ext_hi = r_ext_hi;
        n_ext_lo = r_ext_lo;
        if (w_begin) begin
            n_bl_m1 = i_item.span_left - 64'd1;
            n_bl_p7 = i_item.span_left + SPAN_END_ADD;
            n_cnt   = 4'd0;
            n_phase = w_span_short ? PH_IDLE : PH_HEAD;
        end else if (r_phase != PH_IDLE) begin
            n_bl_m1  = r_bl_m1 - 64'd1;
            n_bl_p7  = r_bl_p7 - 64'd1;
            n_cnt    = r_cnt + 4'd1;
            n_type   = w_type_n;
            n_large  = w_large_n;
            n_ext_hi = w_ext_hi_n;
            n_ext_lo = w_ext_lo_n;
            if ((r_phase == PH_HEAD) && !r_cnt[2]) begin
                n_size = {r_size[23:0], w_b};
            end
            unique case (r_phase)
                PH_HEAD: begin
                    if (w_hd_last && w_size_large && !w_bad) begin
                        n_phase = PH_LARGE;
                        n_cnt   = 4'd0;
                    end
                end
                default: begin
                end
            endcase
            if (w_to_ext && !w_bad) begin
                n_phase = PH_EXT;
                n_cnt   = 4'd0;
            end
            if (w_bad || w_ok) begin
                n_phase = PH_IDLE;
            end
        end
    end

    // Result of the current item.
    always_comb begin
        o_emit   = 1'b0;
        o_result = '0;
        if (w_begin) begin
            o_emit          = w_span_short;
            o_result.status = ST_END;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    o_emit = 1'b0;
                end
                default: begin
                    o_emit            = w_bad || w_ok;
                    o_result.status   = w_ok ? ST_VALID : ST_BAD;
                    o_result.box_type = w_type_n;
                    if (w_ok) begin
                        o_result.payload_bytes = w_diff[63:0];
                        o_result.header_bytes  = w_hdr;
                        o_result.has_extended  = w_uuid;
                        o_result.extended_high = w_uuid ? w_ext_hi_n : 64'd0;
                        o_result.extended_low  = w_uuid ? w_ext_lo_n : 64'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 4'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_bl_m1  <= n_bl_m1;
            r_bl_p7  <= n_bl_p7;
            r_size   <= n_size;
            r_type   <= n_type;
            r_large  <= n_large;
            r_ext_hi <= n_ext_hi;
            r_ext_lo <= n_ext_lo;
        end
    end

    a_idle_data_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) && !w_begin |-> !o_emit)
        else $error("data byte while idle produced a result");

    a_ext_only_from_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (n_phase == PH_EXT) && (r_phase != PH_EXT) |-> w_fixed_done && w_uuid)
        else $error("extended phase entered without a complete uuid header");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEAD) || (r_phase == PH_LARGE) |-> !r_cnt[3])
        else $error("fixed field count out of range");

endmodule
